@@ rtl/assert_macros.svh @@
// Assertion macros shared by the picker RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond holds at every clock edge out of reset
`define ANPP_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// cons holds in the cycle after ante
`define ANPP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/anpp_pkg.sv @@
// Types and constants of the angular nearest point picker.
// No dependencies; used by the top level, anpp_front and anpp_back.
`timescale 1ns / 1ps
package anpp_pkg;

    localparam int COORD_W    = 32;
    localparam int UNIT_W     = 16;
    localparam int VEC_W      = 34;
    localparam int INDEX_W    = 8;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;
    localparam int RED_W      = 24;
    localparam int SQ_W       = 50;
    localparam int PROD_W     = 48;
    localparam int LEN_W      = 25;
    localparam int REM_W      = 26;
    localparam int QUO_W      = 15;
    localparam int DOT_W      = 32;
    localparam int STEP_W     = 5;
    localparam int RAY_STEPS  = 8;
    localparam int SQ_STEPS   = 3;
    localparam int SQRT_STEPS = 25;
    localparam int DIV_STEPS  = 15;
    localparam int DOT_STEPS  = 3;
    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    localparam logic signed [UNIT_W-1:0] QUAT_W_RESET  = 16'sd16384;
    localparam logic signed [UNIT_W-1:0] COS_SEP_RESET = 16'sd15826;
    localparam logic [QUO_W-1:0]         UNIT_ONE      = 15'd16384;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X = 4'd0,
        REG_ORIGIN_Y = 4'd1,
        REG_ORIGIN_Z = 4'd2,
        REG_QUAT_X   = 4'd3,
        REG_QUAT_Y   = 4'd4,
        REG_QUAT_Z   = 4'd5,
        REG_QUAT_W   = 4'd6,
        REG_COS_SEP  = 4'd7
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic                      last_point;
    } item_t;

    typedef struct packed {
        logic                      found;
        logic [INDEX_W-1:0]        pick_index;
        logic signed [COORD_W-1:0] pick_x;
        logic signed [COORD_W-1:0] pick_y;
        logic signed [COORD_W-1:0] pick_z;
    } result_t;

    typedef struct packed {
        item_t                   item;
        logic signed [VEC_W-1:0] dx;
        logic signed [VEC_W-1:0] dy;
        logic signed [VEC_W-1:0] dz;
    } queue_word_t;

    typedef struct packed {
        logic signed [UNIT_W-1:0] qx;
        logic signed [UNIT_W-1:0] qy;
        logic signed [UNIT_W-1:0] qz;
        logic signed [UNIT_W-1:0] qw;
        logic signed [UNIT_W-1:0] cos_sep;
    } ray_cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RAY,
        ST_MAG,
        ST_SHIFT,
        ST_SQ,
        ST_SQRT,
        ST_DIV,
        ST_DOT,
        ST_UPDATE,
        ST_EMIT
    } back_state_t;

endpackage

@@ rtl/angular_nearest_point_picker_unit.sv @@
// Top level of the angular nearest point picker: config registers, front, back.
// Depends on anpp_pkg, anpp_front and anpp_back.
//
// channel   direction  handshake          word
// config    in         cfg_we             cfg_index, cfg_data
// points    in         push / full        item   (item_t)
// picks     out        empty / pop        result (result_t)
//
// A counted point runs one iterative square root (25 steps), three parallel
// restoring dividers (15 steps) and 0 to 10 range shifts.
// The first point after reset or a config write also forms the unit ray; a
// zero vector and points past MAX_POINTS go straight to the update.
// A last point then waits in the emit state while the pick register is full.
// Reset clears all set state; a two-word queue buffers the front from the back.
`timescale 1ns / 1ps
module angular_nearest_point_picker_unit import anpp_pkg::*;
#(
    parameter int MAX_POINTS = 256
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  item_t                 item,
    input  logic                  push,
    output logic                  full,
    output result_t               result,
    output logic                  empty,
    input  logic                  pop
);

    logic signed [COORD_W-1:0] origin_x_reg;
    logic signed [COORD_W-1:0] origin_y_reg;
    logic signed [COORD_W-1:0] origin_z_reg;
    ray_cfg_t                  rcfg_reg;
    queue_word_t               head;
    logic                      head_valid;
    logic                      take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
            origin_z_reg     <= '0;
            rcfg_reg.qx      <= '0;
            rcfg_reg.qy      <= '0;
            rcfg_reg.qz      <= '0;
            rcfg_reg.qw      <= QUAT_W_RESET;
            rcfg_reg.cos_sep <= COS_SEP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ORIGIN_X: origin_x_reg     <= cfg_data;
                REG_ORIGIN_Y: origin_y_reg     <= cfg_data;
                REG_ORIGIN_Z: origin_z_reg     <= cfg_data;
                REG_QUAT_X:   rcfg_reg.qx      <= cfg_data[UNIT_W-1:0];
                REG_QUAT_Y:   rcfg_reg.qy      <= cfg_data[UNIT_W-1:0];
                REG_QUAT_Z:   rcfg_reg.qz      <= cfg_data[UNIT_W-1:0];
                REG_QUAT_W:   rcfg_reg.qw      <= cfg_data[UNIT_W-1:0];
                REG_COS_SEP:  rcfg_reg.cos_sep <= cfg_data[UNIT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    anpp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .push       (push),
        .full       (full),
        .origin_x   (origin_x_reg),
        .origin_y   (origin_y_reg),
        .origin_z   (origin_z_reg),
        .head       (head),
        .head_valid (head_valid),
        .take       (take)
    );

    anpp_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .rcfg       (rcfg_reg),
        .cfg_wr     (cfg_we),
        .head       (head),
        .head_valid (head_valid),
        .take       (take),
        .result     (result),
        .empty      (empty),
        .pop        (pop)
    );

endmodule

@@ rtl/anpp_front.sv @@
// Front end of the picker: input queue, forms the origin-to-point vector.
// Depends on anpp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module anpp_front import anpp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  item_t                     item,
    input  logic                      push,
    output logic                      full,
    input  logic signed [COORD_W-1:0] origin_x,
    input  logic signed [COORD_W-1:0] origin_y,
    input  logic signed [COORD_W-1:0] origin_z,
    output queue_word_t               head,
    output logic                      head_valid,
    input  logic                      take
);

    queue_word_t        slot_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [FCNT_W-1:0]  count_reg;
    queue_word_t        word_in;
    logic               pushing;
    logic               taking;

    assign full       = (count_reg == FCNT_W'(FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];
    assign pushing    = push && !full;
    assign taking     = take && head_valid;

    always_comb
    begin
        word_in.item = item;
        word_in.dx   = {{2{item.point_x[COORD_W-1]}}, item.point_x}
                     - {{2{origin_x[COORD_W-1]}}, origin_x};
        word_in.dy   = {{2{item.point_y[COORD_W-1]}}, item.point_y}
                     - {{2{origin_y[COORD_W-1]}}, origin_y};
        word_in.dz   = {{2{item.point_z[COORD_W-1]}}, item.point_z}
                     - {{2{origin_z[COORD_W-1]}}, origin_z};
    end

    always_ff @(posedge clk)
    begin
        if (pushing)
        begin
            slot_reg[wr_ptr_reg] <= word_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (pushing)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (taking)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (pushing && !taking)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (taking && !pushing)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `ANPP_ASSERT_ALWAYS(a_count_range, count_reg <= FCNT_W'(FIFO_DEPTH), "queue count overflow")
    `ANPP_ASSERT_NEXT(a_count_grow, pushing && !taking, count_reg == $past(count_reg) + 1'b1, "queue count did not grow")

endmodule

@@ rtl/anpp_back.sv @@
// Back end of the picker: ray and point unit vectors, cosine, best tracking.
// Depends on anpp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module anpp_back import anpp_pkg::*;
#(
    parameter int MAX_POINTS = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  ray_cfg_t    rcfg,
    input  logic        cfg_wr,
    input  queue_word_t head,
    input  logic        head_valid,
    output logic        take,
    output result_t     result,
    output logic        empty,
    input  logic        pop
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    back_state_t               state_reg;
    back_state_t               state_next;
    logic [STEP_W-1:0]         step_reg;
    queue_word_t               cur_reg;
    logic                      counted_reg;
    logic                      ray_ok_reg;
    logic                      ray_zero_reg;
    logic                      sel_ray_reg;
    logic                      zero_cos_reg;
    logic signed [VEC_W-1:0]   ray_reg [3];
    logic signed [DOT_W-1:0]   sprod_reg;
    logic [VEC_W-1:0]          mag_reg [3];
    logic                      neg_reg [3];
    logic [VEC_W-1:0]          m_reg;
    logic [PROD_W-1:0]         sqp_reg;
    logic [SQ_W-1:0]           sum_reg;
    logic [SQ_W-1:0]           n_reg;
    logic [SQ_W-1:0]           res_reg;
    logic [SQ_W-1:0]           bit_reg;
    logic [REM_W-1:0]          rem_reg [3];
    logic [QUO_W-1:0]          quo_reg [3];
    logic signed [UNIT_W-1:0]  ur_reg [3];
    logic signed [UNIT_W-1:0]  ud_reg [3];
    logic signed [DOT_W-1:0]   dot_reg;
    logic signed [UNIT_W-1:0]  best_cos_reg;
    logic                      have_best_reg;
    logic [CNT_W-1:0]          best_pos_reg;
    logic signed [COORD_W-1:0] best_x_reg;
    logic signed [COORD_W-1:0] best_y_reg;
    logic signed [COORD_W-1:0] best_z_reg;
    logic [CNT_W-1:0]          cnt_reg;
    result_t                   out_reg;
    logic                      out_valid_reg;

    logic signed [VEC_W-1:0]   vec_sel [3];
    logic [VEC_W-1:0]          mag_in [3];
    logic [VEC_W-1:0]          m_in;
    logic signed [UNIT_W-1:0]  mul_a;
    logic signed [UNIT_W-1:0]  mul_b;
    logic signed [VEC_W-1:0]   p_ext;
    logic [2:0]                role;
    logic [RED_W-1:0]          sq_op;
    logic [SQ_W-1:0]           trial;
    logic                      sq_ge;
    logic [LEN_W-1:0]          len;
    logic [REM_W-1:0]          div_t [3];
    logic                      div_ge [3];
    logic signed [UNIT_W-1:0]  unit_out [3];
    logic [DOT_W-1:0]          dot_mag;
    logic [QUO_W-1:0]          cos_mag;
    logic signed [UNIT_W-1:0]  cos_val;
    logic                      better;
    logic                      found;
    logic                      emit_ok;
    logic                      emit_go;
    logic                      miss_clean;
    logic                      set_clear;
    logic                      under_max;
    logic [CNT_W+INDEX_W-1:0]  pos_ext;

    assign result     = out_reg;
    assign empty      = !out_valid_reg;
    assign emit_ok    = !out_valid_reg || pop;
    assign emit_go    = (state_reg == ST_EMIT) && emit_ok;
    assign under_max  = (cnt_reg < CNT_W'(MAX_POINTS));
    assign pos_ext    = {{INDEX_W{1'b0}}, best_pos_reg};
    assign miss_clean = out_reg.found || (out_reg.pick_index == '0 && out_reg.pick_x == '0);
    assign set_clear  = !have_best_reg && cnt_reg == '0 && !empty;

    always_comb
    begin
        vec_sel[0] = sel_ray_reg ? ray_reg[0] : cur_reg.dx;
        vec_sel[1] = sel_ray_reg ? ray_reg[1] : cur_reg.dy;
        vec_sel[2] = sel_ray_reg ? ray_reg[2] : cur_reg.dz;
        for (int i = 0; i < 3; i++)
        begin
            mag_in[i] = vec_sel[i][VEC_W-1] ? VEC_W'(-vec_sel[i]) : VEC_W'(vec_sel[i]);
        end
        m_in = mag_in[0];
        if (mag_in[1] > m_in)
        begin
            m_in = mag_in[1];
        end
        if (mag_in[2] > m_in)
        begin
            m_in = mag_in[2];
        end
    end

    // shared 16x16 multiplier operands: quaternion products, then dot product
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_RAY)
        begin
            case (step_reg[2:0])
                3'd0:    begin mul_a = rcfg.qx; mul_b = rcfg.qz; end
                3'd1:    begin mul_a = rcfg.qw; mul_b = rcfg.qy; end
                3'd2:    begin mul_a = rcfg.qw; mul_b = rcfg.qx; end
                3'd3:    begin mul_a = rcfg.qy; mul_b = rcfg.qz; end
                3'd4:    begin mul_a = rcfg.qx; mul_b = rcfg.qx; end
                3'd5:    begin mul_a = rcfg.qy; mul_b = rcfg.qy; end
                3'd6:    begin mul_a = rcfg.qz; mul_b = rcfg.qz; end
                default: begin mul_a = rcfg.qw; mul_b = rcfg.qw; end
            endcase
        end
        else
        begin
            case (step_reg[1:0])
                2'd0:    begin mul_a = ur_reg[0]; mul_b = ud_reg[0]; end
                2'd1:    begin mul_a = ur_reg[1]; mul_b = ud_reg[1]; end
                default: begin mul_a = ur_reg[2]; mul_b = ud_reg[2]; end
            endcase
        end
        p_ext = {{2{sprod_reg[DOT_W-1]}}, sprod_reg};
        role  = step_reg[2:0] - 3'd1;
    end

    always_comb
    begin
        case (step_reg[1:0])
            2'd0:    sq_op = mag_reg[0][RED_W-1:0];
            2'd1:    sq_op = mag_reg[1][RED_W-1:0];
            default: sq_op = mag_reg[2][RED_W-1:0];
        endcase
        trial = res_reg + bit_reg;
        sq_ge = (n_reg >= trial);
        len   = res_reg[LEN_W-1:0];
        for (int i = 0; i < 3; i++)
        begin
            div_t[i]    = (step_reg == '0) ? {2'b00, mag_reg[i][RED_W-1:0]}
                                           : {rem_reg[i][REM_W-2:0], 1'b0};
            div_ge[i]   = (div_t[i] >= {1'b0, len});
            unit_out[i] = neg_reg[i] ? -{1'b0, quo_reg[i][QUO_W-2:0], div_ge[i]}
                                     :  {1'b0, quo_reg[i][QUO_W-2:0], div_ge[i]};
        end
    end

    always_comb
    begin
        dot_mag = dot_reg[DOT_W-1] ? DOT_W'(-dot_reg) : DOT_W'(dot_reg);
        cos_mag = (dot_mag[DOT_W-1:14] > {3'b000, UNIT_ONE}) ? UNIT_ONE : dot_mag[28:14];
        if (zero_cos_reg)
        begin
            cos_val = '0;
        end
        else
        begin
            cos_val = dot_reg[DOT_W-1] ? -{1'b0, cos_mag} : {1'b0, cos_mag};
        end
        better = !have_best_reg || (cos_val > best_cos_reg);
        found  = have_best_reg && (best_cos_reg >= rcfg.cos_sep);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    if (!under_max)
                    begin
                        state_next = ST_UPDATE;
                    end
                    else
                    begin
                        state_next = ray_ok_reg ? ST_MAG : ST_RAY;
                    end
                end
            end
            ST_RAY:
            begin
                if (step_reg == STEP_W'(RAY_STEPS))
                begin
                    state_next = ST_MAG;
                end
            end
            ST_MAG:
            begin
                if (m_in == '0 || (!sel_ray_reg && ray_zero_reg))
                begin
                    state_next = ST_UPDATE;
                end
                else
                begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                if (m_reg[VEC_W-1:RED_W] == '0)
                begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                if (step_reg == STEP_W'(SQ_STEPS))
                begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (step_reg == STEP_W'(SQRT_STEPS - 1))
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = sel_ray_reg ? ST_MAG : ST_DOT;
                end
            end
            ST_DOT:
            begin
                if (step_reg == STEP_W'(DOT_STEPS))
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = cur_reg.item.last_point ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (emit_ok)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        take = 1'b0;
        unique case (state_reg)
            ST_IDLE: take = head_valid;
            default: take = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // datapath and set state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            counted_reg   <= 1'b0;
            ray_ok_reg    <= 1'b0;
            ray_zero_reg  <= 1'b0;
            sel_ray_reg   <= 1'b0;
            zero_cos_reg  <= 1'b0;
            best_cos_reg  <= '0;
            have_best_reg <= 1'b0;
            best_pos_reg  <= '0;
            best_x_reg    <= '0;
            best_y_reg    <= '0;
            best_z_reg    <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg <= (state_next != state_reg) ? '0 : step_reg + 1'b1;
            if (emit_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (head_valid)
                    begin
                        counted_reg <= under_max;
                        sel_ray_reg <= !ray_ok_reg;
                    end
                end
                ST_MAG:
                begin
                    zero_cos_reg <= 1'b1;
                    if (sel_ray_reg && m_in == '0)
                    begin
                        ray_zero_reg <= 1'b1;
                        ray_ok_reg   <= 1'b1;
                    end
                end
                ST_DIV:
                begin
                    if (step_reg == STEP_W'(DIV_STEPS - 1) && sel_ray_reg)
                    begin
                        ray_zero_reg <= 1'b0;
                        ray_ok_reg   <= 1'b1;
                        sel_ray_reg  <= 1'b0;
                    end
                end
                ST_DOT:
                begin
                    zero_cos_reg <= 1'b0;
                end
                ST_UPDATE:
                begin
                    if (counted_reg)
                    begin
                        if (better)
                        begin
                            best_cos_reg  <= cos_val;
                            have_best_reg <= 1'b1;
                            best_pos_reg  <= cnt_reg;
                            best_x_reg    <= cur_reg.item.point_x;
                            best_y_reg    <= cur_reg.item.point_y;
                            best_z_reg    <= cur_reg.item.point_z;
                        end
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_EMIT:
                begin
                    if (emit_ok)
                    begin
                        best_cos_reg  <= '0;
                        have_best_reg <= 1'b0;
                        best_pos_reg  <= '0;
                        best_x_reg    <= '0;
                        best_y_reg    <= '0;
                        best_z_reg    <= '0;
                        cnt_reg       <= '0;
                    end
                end
                default:
                begin
                end
            endcase
            if (cfg_wr)
            begin
                ray_ok_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    cur_reg <= head;
                end
                for (int i = 0; i < 3; i++)
                begin
                    ray_reg[i] <= '0;
                end
            end
            ST_RAY:
            begin
                if (step_reg < STEP_W'(RAY_STEPS))
                begin
                    sprod_reg <= mul_a * mul_b;
                end
                if (step_reg != '0)
                begin
                    case (role) inside
                        3'd0, 3'd1: ray_reg[0] <= ray_reg[0] - (p_ext <<< 1);
                        3'd2:       ray_reg[1] <= ray_reg[1] + (p_ext <<< 1);
                        3'd3:       ray_reg[1] <= ray_reg[1] - (p_ext <<< 1);
                        3'd4, 3'd5: ray_reg[2] <= ray_reg[2] + p_ext;
                        default:    ray_reg[2] <= ray_reg[2] - p_ext;
                    endcase
                end
            end
            ST_MAG:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mag_reg[i] <= mag_in[i];
                    neg_reg[i] <= vec_sel[i][VEC_W-1];
                end
                m_reg <= m_in;
            end
            ST_SHIFT:
            begin
                if (m_reg[VEC_W-1:RED_W] != '0)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_reg[i] <= mag_reg[i] >> 1;
                    end
                    m_reg <= m_reg >> 1;
                end
            end
            ST_SQ:
            begin
                sqp_reg <= sq_op * sq_op;
                case (step_reg[1:0])
                    2'd0:    sum_reg <= '0;
                    2'd1:    sum_reg <= {2'b00, sqp_reg};
                    2'd2:    sum_reg <= sum_reg + {2'b00, sqp_reg};
                    default:
                    begin
                        n_reg   <= sum_reg + {2'b00, sqp_reg};
                        res_reg <= '0;
                        bit_reg <= {2'b01, {(SQ_W-2){1'b0}}};
                    end
                endcase
            end
            ST_SQRT:
            begin
                if (sq_ge)
                begin
                    n_reg   <= n_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            ST_DIV:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rem_reg[i] <= div_ge[i] ? div_t[i] - {1'b0, len} : div_t[i];
                    quo_reg[i] <= {quo_reg[i][QUO_W-2:0], div_ge[i]};
                end
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        if (sel_ray_reg)
                        begin
                            ur_reg[i] <= unit_out[i];
                        end
                        else
                        begin
                            ud_reg[i] <= unit_out[i];
                        end
                    end
                end
            end
            ST_DOT:
            begin
                sprod_reg <= mul_a * mul_b;
                case (step_reg[1:0])
                    2'd0:    dot_reg <= '0;
                    2'd1:    dot_reg <= sprod_reg;
                    default: dot_reg <= dot_reg + sprod_reg;
                endcase
            end
            ST_EMIT:
            begin
                if (emit_ok)
                begin
                    out_reg.found      <= found;
                    out_reg.pick_index <= found ? pos_ext[INDEX_W-1:0] : '0;
                    out_reg.pick_x     <= found ? best_x_reg : '0;
                    out_reg.pick_y     <= found ? best_y_reg : '0;
                    out_reg.pick_z     <= found ? best_z_reg : '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    `ANPP_ASSERT_ALWAYS(a_cnt_max, cnt_reg <= CNT_W'(MAX_POINTS), "point count beyond limit")
    `ANPP_ASSERT_ALWAYS(a_miss_zero, empty || miss_clean, "miss word carries data")
    `ANPP_ASSERT_NEXT(a_set_clear, emit_go, set_clear, "set not cleared on emit")

endmodule
